// ----- design/swmr_pkg.sv -----
// shared types and constants for the sliding window range tracker
package swmr_pkg;

    localparam int IN_TDATA_W  = 32;   // sample field, already whole bytes
    localparam int OUT_RANGE_W = 32;   // width of window_range and best_range
    localparam int CFG_W       = 7;    // window_size register width
    localparam int M_TDATA_W   = 72;   // full + range + best, padded to bytes

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(1);

    // control handed to every cell of the window line
    typedef struct packed {
        logic load;    // take a new sample: shift hold line and copy into scan line
        logic scan;    // move the scan line one cell toward the head
    } cell_ctrl_t;

    // control for the min/max tracker at the head of the scan line
    typedef struct packed {
        logic restart; // forget the previous window's extremes
        logic take;    // fold the head cell's scan value in
    } trk_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ----- design/swmr_cell.sv -----
// one cell of the window line: a held sample and its scan copy
module swmr_cell
    import swmr_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   aclk,
    input  cell_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] hold_in,   // from the younger neighbor
    input  logic [SAMPLE_BITS-1:0] scan_in,   // from the older neighbor
    output logic [SAMPLE_BITS-1:0] hold_out,
    output logic [SAMPLE_BITS-1:0] scan_out
);

    logic [SAMPLE_BITS-1:0] hold_reg;
    logic [SAMPLE_BITS-1:0] scan_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            hold_reg <= hold_in;
            scan_reg <= hold_in;
        end else if (ctrl.scan) begin
            scan_reg <= scan_in;
        end
    end

    assign hold_out = hold_reg;
    assign scan_out = scan_reg;

endmodule

// ----- design/swmr_track.sv -----
// running min and max over the scan stream, and their difference
module swmr_track
    import swmr_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  trk_ctrl_t              ctrl,
    input  logic [SAMPLE_BITS-1:0] value,
    output logic [OUT_RANGE_W-1:0] range
);

    localparam int DW = SAMPLE_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_BITS-1:0] hi_reg, hi_next;
    logic                          first_reg, first_next;
    logic signed [SAMPLE_BITS-1:0] v;
    logic [DW-1:0]                 diff;

    assign v = signed'(value);

    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        first_next = first_reg;
        if (ctrl.restart) begin
            first_next = 1'b1;
        end else if (ctrl.take) begin
            first_next = 1'b0;
            if (first_reg || v < lo_reg) begin
                lo_next = v;
            end
            if (first_reg || v > hi_reg) begin
                hi_next = v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else begin
            first_reg <= first_next;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // one bit wider so the difference never wraps
    assign diff = {hi_reg[SAMPLE_BITS-1], hi_reg} - {lo_reg[SAMPLE_BITS-1], lo_reg};

    generate
        if (DW >= OUT_RANGE_W) begin : g_cut
            assign range = diff[OUT_RANGE_W-1:0];
        end else begin : g_ext
            assign range = {{(OUT_RANGE_W-DW){1'b0}}, diff};
        end
    endgenerate

endmodule

// ----- design/sliding_window_min_range.sv -----
// top level of the sliding window range tracker
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tdata      | tdata[31:0] sample, tuser[0] start_flag
//           | s_tuser                        |
//  result   | m_tvalid m_tready m_tdata      | tdata[0] window_full, [32:1] window_range,
//           |                                | [64:33] best_range, [71:65] zero
//  config   | cfg_valid cfg_ready cfg_data   | cfg_data[6:0] window_size
//
// a sample goes straight from idle to done until the window is full, then through
// the scan state, k being the effective window size: the scan line walks the last k
// samples past the min/max tracker at the head, one cell per cycle
// the next sample is taken while the previous result still waits on m_tready
// reset clears the fill count, the best range and the state; held samples are
// not cleared, the fill count keeps them from being read
// config is written only while no sample is in flight; the block does not enforce it
module sliding_window_min_range
    import swmr_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [31:0] sample
    input  logic [0:0]            s_tuser,   // [0] start_flag
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] full, [32:1] range, [64:33] best
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data   // [6:0] window_size
);

    localparam int CW = $clog2(WINDOW_MAX + 1);       // fill count width
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;    // compare width for sizes

    // config register
    logic [CFG_W-1:0] cfg_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_size_reg <= CFG_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cfg_size_reg <= cfg_data;
        end
    end

    // effective window: zero means one, above the line length saturates
    logic [KW-1:0] size_ext;
    logic [KW-1:0] k_eff;

    assign size_ext = KW'(cfg_size_reg);

    always_comb begin
        priority if (size_ext == '0) begin
            k_eff = KW'(1);
        end else if (size_ext > KW'(WINDOW_MAX)) begin
            k_eff = KW'(WINDOW_MAX);
        end else begin
            k_eff = size_ext;
        end
    end

    // control state
    state_t                 state_reg, state_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [KW-1:0]          cnt_reg, cnt_next;
    logic                   full_reg, full_next;
    logic [OUT_RANGE_W-1:0] best_reg, best_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   in_fire;
    logic                   out_free;
    logic [CW-1:0]          fill_inc;
    logic [OUT_RANGE_W-1:0] win_range;
    logic [OUT_RANGE_W-1:0] range_out;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // fill count saturates at the line length
    assign fill_inc = (fill_reg < CW'(WINDOW_MAX)) ? fill_reg + CW'(1) : fill_reg;

    assign range_out = full_reg ? win_range : '0;

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        cnt_next      = cnt_reg;
        full_next     = full_reg;
        best_next     = best_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    // start flag opens a new sequence before this sample lands
                    if (s_tuser[0]) begin
                        fill_next = CW'(1);
                        best_next = '1;
                    end else begin
                        fill_next = fill_inc;
                    end
                    full_next  = (KW'(fill_next) >= k_eff);
                    cnt_next   = '0;
                    state_next = full_next ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + KW'(1);
                if (cnt_reg == k_eff - KW'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (full_reg && win_range < best_reg) begin
                        best_next = win_range;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - 2*OUT_RANGE_W - 1){1'b0}},
                                     best_next, range_out, full_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            cnt_reg      <= '0;
            full_reg     <= 1'b0;
            best_reg     <= '1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            cnt_reg      <= cnt_next;
            full_reg     <= full_next;
            best_reg     <= best_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // incoming sample: low SAMPLE_BITS of the field, or the field zero-extended
    logic [SAMPLE_BITS-1:0] new_sample;

    generate
        if (SAMPLE_BITS <= IN_TDATA_W) begin : g_narrow
            assign new_sample = s_tdata[SAMPLE_BITS-1:0];
        end else begin : g_wide
            assign new_sample = {{(SAMPLE_BITS-IN_TDATA_W){1'b0}}, s_tdata};
        end
    endgenerate

    // window line: cell 0 holds the newest sample, scan line drains toward cell 0
    cell_ctrl_t             cell_ctrl;
    logic [SAMPLE_BITS-1:0] hold_q [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] scan_q [WINDOW_MAX];

    assign cell_ctrl.load = in_fire;
    assign cell_ctrl.scan = (state_reg == ST_SCAN);

    generate
        for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
            logic [SAMPLE_BITS-1:0] hold_in;
            logic [SAMPLE_BITS-1:0] scan_in;

            if (i == 0) begin : g_head
                assign hold_in = new_sample;
            end else begin : g_body
                assign hold_in = hold_q[i-1];
            end

            if (i == WINDOW_MAX - 1) begin : g_tail
                assign scan_in = '0;
            end else begin : g_link
                assign scan_in = scan_q[i+1];
            end

            swmr_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl),
                .hold_in  (hold_in),
                .scan_in  (scan_in),
                .hold_out (hold_q[i]),
                .scan_out (scan_q[i])
            );
        end
    endgenerate

    // min/max at the head of the scan line
    trk_ctrl_t trk_ctrl;

    assign trk_ctrl.restart = in_fire;
    assign trk_ctrl.take    = (state_reg == ST_SCAN);

    swmr_track #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (trk_ctrl),
        .value   (scan_q[0]),
        .range   (win_range)
    );

endmodule

// ----- design/swmr_checker.sv -----
// port-level checks for the sliding window range tracker, bound to the top level
module swmr_checker
    import swmr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // a stalled result keeps valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a window that is not full reports a zero range
    a_empty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0)
        else $error("nonzero range before window full");

    // the best range never exceeds the current full-window range
    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[64:33] <= m_tdata[32:1])
        else $error("best range above current range");

endmodule

bind sliding_window_min_range swmr_checker u_swmr_checker (.*);

// ----- test/sliding_window_min_range_tb.sv -----
// self-checking testbench for the sliding window range tracker
`timescale 1ns / 1ps

module sliding_window_min_range_tb
    import swmr_pkg::*;
;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int RANDOM_ITEMS = 600;
    localparam int BURST_ITEMS  = 100;
    localparam int SETTLE_CYCLES = WINDOW_MAX + 8;   // longer than one scan of a full window

    // one result transaction split into its fields
    typedef struct packed {
        logic                   full;
        logic [OUT_RANGE_W-1:0] span;
        logic [OUT_RANGE_W-1:0] best;
    } range_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // shadow copy of the tracker state
    logic signed [SAMPLE_BITS-1:0] held_samples [WINDOW_MAX];
    int                            held_count;
    int                            next_slot;
    logic [OUT_RANGE_W-1:0]        best_seen;
    logic [CFG_W-1:0]              size_reg;

    range_result_t expected_results [$];

    // gates random idling on both sides
    logic idle_en = 1'b1;

    int failures      = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int size_writes   = 0;
    int full_results  = 0;
    logic [IN_TDATA_W-1:0] phase_base;

    sliding_window_min_range #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // hard limit far beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // advance the shadow state by one accepted sample and return the expected result
    function automatic range_result_t track_sample(logic [IN_TDATA_W-1:0] raw, logic start);
        int            k;
        int            idx;
        longint        lo;
        longint        hi;
        longint        v;
        range_result_t r;
        k = (size_reg == 0) ? 1 : ((size_reg > WINDOW_MAX) ? WINDOW_MAX : int'(size_reg));
        if (start) begin
            held_count = 0;
            next_slot  = 0;
            best_seen  = '1;
        end
        held_samples[next_slot] = raw[SAMPLE_BITS-1:0];
        next_slot = (next_slot + 1) % WINDOW_MAX;
        if (held_count < WINDOW_MAX)
            held_count++;
        r.full = (held_count >= k);
        r.span = '0;
        if (r.full) begin
            lo = 0;
            hi = 0;
            for (int i = 0; i < k; i++) begin
                idx = (next_slot + WINDOW_MAX - 1 - i) % WINDOW_MAX;
                v   = longint'(held_samples[idx]);
                if (i == 0 || v < lo)
                    lo = v;
                if (i == 0 || v > hi)
                    hi = v;
            end
            r.span = OUT_RANGE_W'(hi - lo);
            if (r.span < best_seen)
                best_seen = r.span;
        end
        r.best = best_seen;
        return r;
    endfunction

    // one sample transaction; entered and left at a falling edge
    task automatic send_sample(logic [IN_TDATA_W-1:0] value, logic start);
        if (idle_en && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_results.insert(expected_results.size(), track_sample(value, start));
        samples_sent++;
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0 && waited < 200000) begin
            @(negedge aclk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            failures += expected_results.size();
            expected_results.delete();
        end
        // the block may still be finishing its scan after the last handshake
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // config transaction; only called with the block idle
    task automatic write_window_size(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        size_reg = value;
        size_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // mix of wide random, clustered, extreme and near-zero samples
    function automatic logic [IN_TDATA_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom;
        else if (sel < 8)
            return phase_base + IN_TDATA_W'($urandom_range(0, 15)) - IN_TDATA_W'(8);
        else if (sel == 8)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
    endfunction

    // result side backpressure
    always @(negedge aclk) begin
        m_tready <= !idle_en || ($urandom_range(0, 99) >= 20);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        range_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: tdata %h", m_tdata);
                failures++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (want.full)
                    full_results++;
                if (m_tdata[0] !== want.full) begin
                    $error("window_full: expected %0d, actual %0d", want.full, m_tdata[0]);
                    failures++;
                end
                if (m_tdata[32:1] !== want.span) begin
                    $error("window_range: expected %h, actual %h", want.span, m_tdata[32:1]);
                    failures++;
                end
                if (m_tdata[64:33] !== want.best) begin
                    $error("best_range: expected %h, actual %h", want.best, m_tdata[64:33]);
                    failures++;
                end
                if (m_tdata[M_TDATA_W-1:65] !== '0) begin
                    $error("pad: expected 0, actual %h", m_tdata[M_TDATA_W-1:65]);
                    failures++;
                end
            end
        end
    end

    // reset value of the window size is 1, so every sample is a full window
    task automatic test_reset_size();
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        drain_results();
    endtask

    // not-full window, widest possible range, then a narrowing best
    task automatic test_extreme_range();
        write_window_size(CFG_W'(2));
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        drain_results();
    endtask

    // a size of zero behaves as a size of one
    task automatic test_size_zero();
        write_window_size(CFG_W'(0));
        send_sample(32'd5, 1'b1);
        send_sample(32'd9, 1'b0);
        drain_results();
    endtask

    // shrink the window mid-sequence, then restart with the start flag
    task automatic test_size_change();
        write_window_size(CFG_W'(4));
        send_sample(32'd10, 1'b1);
        send_sample(32'd20, 1'b0);
        send_sample(32'd30, 1'b0);
        send_sample(32'd40, 1'b0);
        send_sample(32'd50, 1'b0);
        drain_results();
        // best range carries over, new size applies to held samples
        write_window_size(CFG_W'(2));
        send_sample(32'd45, 1'b0);
        send_sample(32'd100, 1'b0);
        send_sample(32'hFFFF_FFF0, 1'b1);
        send_sample(32'd3, 1'b0);
        drain_results();
    endtask

    // sizes above the store depth clamp to the store depth
    task automatic test_size_clamp();
        write_window_size(CFG_W'(127));
        send_sample(32'h1234_5678, 1'b1);
        send_sample(32'hEDCB_A987, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        drain_results();
    endtask

    // random sequences over many window sizes, mostly well formed
    task automatic test_random_sequences();
        int            target;
        int            k_eff;
        int            count;
        int            restart_odds;
        logic [CFG_W-1:0] size_val;
        target = samples_sent + RANDOM_ITEMS;
        while (samples_sent < target) begin
            case ($urandom_range(0, 9))
                0: size_val = CFG_W'(0);
                1: size_val = CFG_W'(1);
                2: size_val = CFG_W'(WINDOW_MAX);
                3: size_val = CFG_W'(127);
                4: size_val = CFG_W'($urandom_range(WINDOW_MAX + 1, 127));
                default: size_val = CFG_W'($urandom_range(2, 10));
            endcase
            write_window_size(size_val);
            k_eff = (size_val == 0) ? 1 : ((size_val > WINDOW_MAX) ? WINDOW_MAX : int'(size_val));
            count = k_eff + $urandom_range(4, 40);
            // one phase in six breaks sequences up with frequent restarts
            restart_odds = ($urandom_range(0, 5) == 0) ? 3 : 4 * k_eff + 8;
            phase_base = $urandom;
            // a phase without a leading restart keeps the previous sequence going
            send_sample(pick_sample(), $urandom_range(0, 3) != 0);
            for (int i = 1; i < count; i++)
                send_sample(pick_sample(), $urandom_range(0, restart_odds) == 0);
            drain_results();
        end
    endtask

    // back-to-back traffic with neither side idling
    task automatic test_unthrottled_burst();
        idle_en = 1'b0;
        write_window_size(CFG_W'($urandom_range(2, 8)));
        phase_base = $urandom;
        send_sample(pick_sample(), 1'b1);
        for (int i = 1; i < BURST_ITEMS; i++)
            send_sample(pick_sample(), $urandom_range(0, 40) == 0);
        drain_results();
        idle_en = 1'b1;
    endtask

    initial begin
        held_count = 0;
        next_slot  = 0;
        best_seen  = '1;
        size_reg   = CFG_SIZE_RESET;
        for (int i = 0; i < WINDOW_MAX; i++)
            held_samples[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_size();
        test_extreme_range();
        test_size_zero();
        test_size_change();
        test_size_clamp();
        test_random_sequences();
        test_unthrottled_burst();

        $display("sent %0d samples, checked %0d results (%0d with a full window)",
                 samples_sent, results_seen, full_results);
        $display("window size written %0d times, including 0, 1, 64 and 127", size_writes);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/swmr_pkg.sv
design/swmr_cell.sv
design/swmr_track.sv
design/sliding_window_min_range.sv
design/swmr_checker.sv
test/sliding_window_min_range_tb.sv
